>>> hdl/ccl_pkg.sv
// Shared types, widths and register codes for the cubic curve line restriction unit.
// Used by the datapath, the top level and the port checker; depends on nothing.
`default_nettype none

package ccl_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH = 32;
    localparam int COORD_FRAC = COORD_WIDTH / 2;
    localparam int COEF_FRAC = COEF_WIDTH - 2;
    localparam int OUT_FRAC = 32;
    localparam int OUT_WIDTH = 64;
    localparam int PROD_FRAC = COEF_FRAC + 3 * COORD_FRAC;
    localparam int DROP = PROD_FRAC - OUT_FRAC;
    localparam int SUM_WIDTH = 136;
    localparam int REG_WIDTH = 64;
    localparam int HALF_WIDTH = REG_WIDTH / 2;
    localparam int NUM_REGS = 5;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_STAGES = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_PAIR_0 = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_PAIR_1 = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_PAIR_2 = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_PAIR_3 = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEF_PAIR_4 = 3'd4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef logic signed [SUM_WIDTH-1:0] sum_t;
    typedef logic signed [OUT_WIDTH-1:0] out_coef_t;

    localparam out_coef_t SAT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam out_coef_t SAT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef struct packed {
        coef_t a000;
        coef_t a001;
        coef_t a002;
        coef_t a011;
        coef_t a012;
        coef_t a022;
        coef_t a111;
        coef_t a112;
        coef_t a122;
        coef_t a222;
    } coef_set_t;

    typedef struct packed {
        sum_t t3;
        sum_t t2;
        sum_t t1;
        sum_t t0;
    } sum_set_t;

endpackage

`default_nettype wire

>>> hdl/ccl_core.sv
// Eight-stage product pipeline that expands the cubic along a line into exact sums per power of t.
// Depends on ccl_pkg; stage advance enables come from the top level.
`default_nettype none

module ccl_core
    import ccl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic [NUM_STAGES-1:0] adv,
    input  wire coef_set_t             coefs,
    input  wire coord_t                point_x,
    input  wire coord_t                point_y,
    input  wire coord_t                dir_x,
    input  wire coord_t                dir_y,
    output      sum_set_t              sums
);

    localparam int LIMB = 33;
    localparam int R_W = 2 * LIMB;
    localparam int P_W = 3 * LIMB + 1;
    localparam int PP_W = LIMB + 1 + COORD_WIDTH;
    localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [R_W-1:0] r_t;
    typedef logic signed [P_W-1:0] p_t;
    typedef logic signed [PP_W-1:0] pp_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t vx;
        coord_t vy;
    } line_t;

    typedef struct packed {
        pp_t hi;
        pp_t lo;
    } pp2_t;

    typedef struct packed {
        pp2_t pc;
        pp2_t pl;
        pp2_t vc;
        pp2_t vl;
    } lin_pp_t;

    typedef struct packed {
        p_t pc;
        p_t pl;
        p_t vc;
        p_t vl;
    } lin_prod_t;

    typedef struct packed {
        pp_t l2;
        pp_t l1;
        pp_t l0;
    } pp3_t;

    typedef struct packed {
        pp3_t p0;
        pp3_t p1;
        pp3_t p2;
        pp3_t v0;
        pp3_t v1;
        pp3_t v2;
    } quad_pp_t;

    typedef struct packed {
        sum_t p0;
        sum_t p1;
        sum_t p2;
        sum_t v0;
        sum_t v1;
        sum_t v2;
    } quad_prod_t;

    typedef struct packed {
        p_t c0;
        p_t c1;
        p_t c2;
    } quad_t;

    function automatic pp2_t mul_r(coord_t c, r_t r);
        pp2_t res;
        res.lo = pp_t'(c) * pp_t'($signed({1'b0, r[LIMB-1:0]}));
        res.hi = pp_t'(c) * pp_t'($signed(r[R_W-1:LIMB]));
        return res;
    endfunction

    function automatic p_t join2(pp2_t pp);
        return (p_t'(pp.hi) <<< LIMB) + p_t'(pp.lo);
    endfunction

    function automatic lin_pp_t mul_line(coord_t p, coord_t v, r_t c, r_t l);
        lin_pp_t res;
        res.pc = mul_r(p, c);
        res.pl = mul_r(p, l);
        res.vc = mul_r(v, c);
        res.vl = mul_r(v, l);
        return res;
    endfunction

    function automatic lin_prod_t join_line(lin_pp_t pp);
        lin_prod_t res;
        res.pc = join2(pp.pc);
        res.pl = join2(pp.pl);
        res.vc = join2(pp.vc);
        res.vl = join2(pp.vl);
        return res;
    endfunction

    function automatic pp3_t mul_p(coord_t c, p_t q);
        pp3_t res;
        res.l0 = pp_t'(c) * pp_t'($signed({1'b0, q[LIMB-1:0]}));
        res.l1 = pp_t'(c) * pp_t'($signed({1'b0, q[2*LIMB-1:LIMB]}));
        res.l2 = pp_t'(c) * pp_t'($signed(q[P_W-1:2*LIMB]));
        return res;
    endfunction

    function automatic sum_t join3(pp3_t pp);
        return (sum_t'(pp.l2) <<< (2 * LIMB)) + (sum_t'(pp.l1) <<< LIMB) + sum_t'(pp.l0);
    endfunction

    function automatic quad_pp_t mul_quad(coord_t p, coord_t v, quad_t q);
        quad_pp_t res;
        res.p0 = mul_p(p, q.c0);
        res.p1 = mul_p(p, q.c1);
        res.p2 = mul_p(p, q.c2);
        res.v0 = mul_p(v, q.c0);
        res.v1 = mul_p(v, q.c1);
        res.v2 = mul_p(v, q.c2);
        return res;
    endfunction

    function automatic quad_prod_t join_quad(quad_pp_t pp);
        quad_prod_t res;
        res.p0 = join3(pp.p0);
        res.p1 = join3(pp.p1);
        res.p2 = join3(pp.p2);
        res.v0 = join3(pp.v0);
        res.v1 = join3(pp.v1);
        res.v2 = join3(pp.v2);
        return res;
    endfunction

    line_t      s1_line_reg;
    line_t      s2_line_reg;
    line_t      s3_line_reg;
    line_t      s4_line_reg;
    line_t      s5_line_reg;
    prod_t      s1_a111_px_reg;
    prod_t      s1_a111_vx_reg;
    prod_t      s1_a112_py_reg;
    prod_t      s1_a112_vy_reg;
    prod_t      s1_a122_py_reg;
    prod_t      s1_a122_vy_reg;
    prod_t      s1_a222_py_reg;
    prod_t      s1_a222_vy_reg;
    r_t         s2_r1c_reg;
    r_t         s2_r1l_reg;
    r_t         s2_r2c_reg;
    r_t         s2_r2l_reg;
    r_t         s2_r3c_reg;
    r_t         s2_r3l_reg;
    lin_pp_t    s3_xr1_reg;
    lin_pp_t    s3_yr2_reg;
    lin_pp_t    s3_yr3_reg;
    lin_prod_t  s4_xr1_reg;
    lin_prod_t  s4_yr2_reg;
    lin_prod_t  s4_yr3_reg;
    quad_t      s5_p_reg;
    quad_t      s5_q_reg;
    quad_pp_t   s6_xp_reg;
    quad_pp_t   s6_yq_reg;
    quad_prod_t s7_xp_reg;
    quad_prod_t s7_yq_reg;
    sum_set_t   s8_sum_reg;

    // The innermost linear forms of the nested expansion are formed first.
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_line_reg    <= '{px: point_x, py: point_y, vx: dir_x, vy: dir_y};
            s1_a111_px_reg <= prod_t'(coefs.a111) * prod_t'(point_x);
            s1_a111_vx_reg <= prod_t'(coefs.a111) * prod_t'(dir_x);
            s1_a112_py_reg <= prod_t'(coefs.a112) * prod_t'(point_y);
            s1_a112_vy_reg <= prod_t'(coefs.a112) * prod_t'(dir_y);
            s1_a122_py_reg <= prod_t'(coefs.a122) * prod_t'(point_y);
            s1_a122_vy_reg <= prod_t'(coefs.a122) * prod_t'(dir_y);
            s1_a222_py_reg <= prod_t'(coefs.a222) * prod_t'(point_y);
            s1_a222_vy_reg <= prod_t'(coefs.a222) * prod_t'(dir_y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s2_line_reg <= s1_line_reg;
            s2_r1c_reg  <= (r_t'(coefs.a011) <<< COORD_FRAC) + r_t'(s1_a111_px_reg)
                           + r_t'(s1_a112_py_reg);
            s2_r1l_reg  <= r_t'(s1_a111_vx_reg) + r_t'(s1_a112_vy_reg);
            s2_r2c_reg  <= (r_t'(coefs.a012) <<< COORD_FRAC) + r_t'(s1_a122_py_reg);
            s2_r2l_reg  <= r_t'(s1_a122_vy_reg);
            s2_r3c_reg  <= (r_t'(coefs.a022) <<< COORD_FRAC) + r_t'(s1_a222_py_reg);
            s2_r3l_reg  <= r_t'(s1_a222_vy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s3_line_reg <= s2_line_reg;
            s3_xr1_reg  <= mul_line(s2_line_reg.px, s2_line_reg.vx, s2_r1c_reg, s2_r1l_reg);
            s3_yr2_reg  <= mul_line(s2_line_reg.py, s2_line_reg.vy, s2_r2c_reg, s2_r2l_reg);
            s3_yr3_reg  <= mul_line(s2_line_reg.py, s2_line_reg.vy, s2_r3c_reg, s2_r3l_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s4_line_reg <= s3_line_reg;
            s4_xr1_reg  <= join_line(s3_xr1_reg);
            s4_yr2_reg  <= join_line(s3_yr2_reg);
            s4_yr3_reg  <= join_line(s3_yr3_reg);
        end
    end

    // The two quadratics in t that multiply x and y in the outer level.
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_line_reg <= s4_line_reg;
            s5_p_reg.c0 <= (p_t'(coefs.a001) <<< (2 * COORD_FRAC)) + s4_xr1_reg.pc
                           + s4_yr2_reg.pc;
            s5_p_reg.c1 <= s4_xr1_reg.pl + s4_xr1_reg.vc + s4_yr2_reg.pl + s4_yr2_reg.vc;
            s5_p_reg.c2 <= s4_xr1_reg.vl + s4_yr2_reg.vl;
            s5_q_reg.c0 <= (p_t'(coefs.a002) <<< (2 * COORD_FRAC)) + s4_yr3_reg.pc;
            s5_q_reg.c1 <= s4_yr3_reg.pl + s4_yr3_reg.vc;
            s5_q_reg.c2 <= s4_yr3_reg.vl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_xp_reg <= mul_quad(s5_line_reg.px, s5_line_reg.vx, s5_p_reg);
            s6_yq_reg <= mul_quad(s5_line_reg.py, s5_line_reg.vy, s5_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s7_xp_reg <= join_quad(s6_xp_reg);
            s7_yq_reg <= join_quad(s6_yq_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s8_sum_reg.t3 <= s7_xp_reg.v2 + s7_yq_reg.v2;
            s8_sum_reg.t2 <= s7_xp_reg.p2 + s7_xp_reg.v1 + s7_yq_reg.p2 + s7_yq_reg.v1;
            s8_sum_reg.t1 <= s7_xp_reg.p1 + s7_xp_reg.v0 + s7_yq_reg.p1 + s7_yq_reg.v0;
            s8_sum_reg.t0 <= s7_xp_reg.p0 + s7_yq_reg.p0
                             + (sum_t'(coefs.a000) <<< (3 * COORD_FRAC));
        end
    end

    assign sums = s8_sum_reg;

endmodule

`default_nettype wire

>>> hdl/cubic_curve_line_restriction_unit.sv
// Top level: coefficient registers, pipeline flow control and the rounding output stage.
// Depends on ccl_pkg and instantiates ccl_core.
//
// Usage. Five 64-bit coefficient registers are loaded through the write port
// (cfg_we, cfg_index, cfg_data) while no transaction is in flight; a write to
// an index beyond the fifth register is ignored. Each input transaction carries
// a line as base point and direction; each output transaction carries the four
// coefficients of the cubic in t along that line and an overflow flag.
// Both channels transfer when valid is high and stall is low.
// A line passes nine register stages: the core stages and the output register.
// Throughput is one line per cycle while the output is not stalled, set by the fully pipelined product tree.
// Reset clears the coefficients and every valid bit; no result is shown.
// A stalled output holds its result; stages behind it keep filling empty
// slots, and the input stalls only when every stage holds a line.

`default_nettype none

module cubic_curve_line_restriction_unit
    import ccl_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [REG_WIDTH-1:0]       cfg_data,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire coord_t                     point_x,
    input  wire coord_t                     point_y,
    input  wire coord_t                     dir_x,
    input  wire coord_t                     dir_y,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      out_coef_t                  t_cubed_coef,
    output      out_coef_t                  t_squared_coef,
    output      out_coef_t                  t_linear_coef,
    output      out_coef_t                  t_constant_coef,
    output      logic                       overflow
);

    localparam sum_t RND = sum_t'(1) <<< (DROP - 1);
    localparam int SIGN_LSB = DROP + OUT_WIDTH - 1;

    typedef struct packed {
        logic      ovf;
        out_coef_t value;
    } sat_res_t;

    function automatic sat_res_t round_sat(sum_t s);
        sat_res_t res;
        sum_t     r;
        logic     all0;
        logic     all1;
        r    = s + RND;
        all0 = ~|r[SUM_WIDTH-1:SIGN_LSB];
        all1 = &r[SUM_WIDTH-1:SIGN_LSB];
        if (all0 || all1)
        begin
            res.ovf   = 1'b0;
            res.value = r[SIGN_LSB:DROP];
        end
        else if (r[SUM_WIDTH-1])
        begin
            res.ovf   = 1'b1;
            res.value = SAT_MIN;
        end
        else
        begin
            res.ovf   = 1'b1;
            res.value = SAT_MAX;
        end
        return res;
    endfunction

    logic [REG_WIDTH-1:0]  coef_pair_reg [NUM_REGS];
    coef_set_t             coefs;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;
    logic                  out_adv;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    sum_set_t              sums;
    sat_res_t              sat3;
    sat_res_t              sat2;
    sat_res_t              sat1;
    sat_res_t              sat0;
    out_coef_t             t_cubed_coef_reg;
    out_coef_t             t_squared_coef_reg;
    out_coef_t             t_linear_coef_reg;
    out_coef_t             t_constant_coef_reg;
    logic                  overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_pair_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_PAIR_0: coef_pair_reg[0] <= cfg_data;
                CFG_COEF_PAIR_1: coef_pair_reg[1] <= cfg_data;
                CFG_COEF_PAIR_2: coef_pair_reg[2] <= cfg_data;
                CFG_COEF_PAIR_3: coef_pair_reg[3] <= cfg_data;
                CFG_COEF_PAIR_4: coef_pair_reg[4] <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        coefs.a000 = coef_pair_reg[0][COEF_WIDTH-1:0];
        coefs.a001 = coef_pair_reg[0][HALF_WIDTH+COEF_WIDTH-1:HALF_WIDTH];
        coefs.a002 = coef_pair_reg[1][COEF_WIDTH-1:0];
        coefs.a011 = coef_pair_reg[1][HALF_WIDTH+COEF_WIDTH-1:HALF_WIDTH];
        coefs.a012 = coef_pair_reg[2][COEF_WIDTH-1:0];
        coefs.a022 = coef_pair_reg[2][HALF_WIDTH+COEF_WIDTH-1:HALF_WIDTH];
        coefs.a111 = coef_pair_reg[3][COEF_WIDTH-1:0];
        coefs.a112 = coef_pair_reg[3][HALF_WIDTH+COEF_WIDTH-1:HALF_WIDTH];
        coefs.a122 = coef_pair_reg[4][COEF_WIDTH-1:0];
        coefs.a222 = coef_pair_reg[4][HALF_WIDTH+COEF_WIDTH-1:HALF_WIDTH];
    end

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        out_adv                 = !out_valid_reg || !out_stall;
        adv[NUM_STAGES-1]       = !valid_reg[NUM_STAGES-1] || out_adv;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
        out_valid_next = out_adv ? valid_reg[NUM_STAGES-1] : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    ccl_core u_core (
        .clk     (clk),
        .adv     (adv),
        .coefs   (coefs),
        .point_x (point_x),
        .point_y (point_y),
        .dir_x   (dir_x),
        .dir_y   (dir_y),
        .sums    (sums)
    );

    always_comb
    begin
        sat3 = round_sat(sums.t3);
        sat2 = round_sat(sums.t2);
        sat1 = round_sat(sums.t1);
        sat0 = round_sat(sums.t0);
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            t_cubed_coef_reg    <= sat3.value;
            t_squared_coef_reg  <= sat2.value;
            t_linear_coef_reg   <= sat1.value;
            t_constant_coef_reg <= sat0.value;
            overflow_reg        <= sat3.ovf | sat2.ovf | sat1.ovf | sat0.ovf;
        end
    end

    assign in_stall        = !adv[0];
    assign out_valid       = out_valid_reg;
    assign t_cubed_coef    = t_cubed_coef_reg;
    assign t_squared_coef  = t_squared_coef_reg;
    assign t_linear_coef   = t_linear_coef_reg;
    assign t_constant_coef = t_constant_coef_reg;
    assign overflow        = overflow_reg;

endmodule

`default_nettype wire

>>> hdl/ccl_checker.sv
// Port-level checker for the cubic curve line restriction unit, bound to the top level.
// Depends on ccl_pkg; sees only the top level's ports.
`default_nettype none

module ccl_checker
    import ccl_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       cfg_we,
    input wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input wire logic [REG_WIDTH-1:0]       cfg_data,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire coord_t                     point_x,
    input wire coord_t                     point_y,
    input wire coord_t                     dir_x,
    input wire coord_t                     dir_y,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire out_coef_t                  t_cubed_coef,
    input wire out_coef_t                  t_squared_coef,
    input wire out_coef_t                  t_linear_coef,
    input wire out_coef_t                  t_constant_coef,
    input wire logic                       overflow
);

    // The input can only be held back by a full pipeline behind a stalled result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result at the output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(t_cubed_coef)
            && $stable(t_squared_coef) && $stable(t_linear_coef)
            && $stable(t_constant_coef) && $stable(overflow)))
        else $error("stalled result transaction changed");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (t_cubed_coef == SAT_MAX || t_cubed_coef == SAT_MIN
            || t_squared_coef == SAT_MAX || t_squared_coef == SAT_MIN
            || t_linear_coef == SAT_MAX || t_linear_coef == SAT_MIN
            || t_constant_coef == SAT_MAX || t_constant_coef == SAT_MIN))
        else $error("overflow flagged without a saturated coefficient");

endmodule

bind cubic_curve_line_restriction_unit ccl_checker u_ccl_checker (.*);

`default_nettype wire
